### rtl/abfsa_pkg.sv
// Package: field widths, constants and shared types of the A/B feed sequence arbiter.
`default_nettype none

package abfsa_pkg;

	localparam int SEQ_W        = 32;
	localparam int HANDLE_W     = 16;
	localparam int LEN_W        = 11;
	localparam int HELD_COUNT_W = 7;
	localparam int DROP_W       = 32;
	localparam int PAYLOAD_W    = HANDLE_W + LEN_W;

	localparam logic [DROP_W-1:0] DROP_MAX = '1;

	// request classification against the next expected number
	typedef struct packed {
		logic is_next;
		logic is_old;
		logic is_far;
	} seq_class_t;

endpackage

`default_nettype wire

### rtl/abfsa_if.sv
// Interfaces: arrival channel and delivery channel of the A/B feed sequence arbiter.
`default_nettype none

interface abfsa_in_if import abfsa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SEQ_W-1:0]    seq_num;
	logic [HANDLE_W-1:0] payload_handle;
	logic [LEN_W-1:0]    payload_len;

	modport source (output valid, output seq_num, output payload_handle, output payload_len,
		input ready);
	modport sink (input valid, input seq_num, input payload_handle, input payload_len,
		output ready);
endinterface

interface abfsa_out_if import abfsa_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [SEQ_W-1:0]        out_seq;
	logic [HANDLE_W-1:0]     out_handle;
	logic [LEN_W-1:0]        out_len;
	logic                    last_of_run;
	logic [HELD_COUNT_W-1:0] held_count;
	logic [DROP_W-1:0]       drop_total;

	modport source (output valid, output out_seq, output out_handle, output out_len,
		output last_of_run, output held_count, output drop_total, input ready);
	modport sink (input valid, input out_seq, input out_handle, input out_len,
		input last_of_run, input held_count, input drop_total, output ready);
endinterface

`default_nettype wire

### rtl/abfsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module abfsa_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/abfsa_classify.sv
// Sequence classifier: compares a request number against the next expected number.
`default_nettype none

module abfsa_classify import abfsa_pkg::*; #(
	parameter int SEQ_BITS     = 32,
	parameter int WINDOW_SLOTS = 64
) (
	input  wire logic [SEQ_BITS-1:0] seq,
	input  wire logic [SEQ_BITS-1:0] next_exp,
	output seq_class_t               cls
);

	logic [SEQ_BITS-1:0] seq_gap;

	assign seq_gap = seq - next_exp;

	always_comb begin
		cls.is_next = (seq == next_exp);
		cls.is_old  = (seq < next_exp);
		cls.is_far  = !cls.is_next && !cls.is_old && (seq_gap >= SEQ_BITS'(WINDOW_SLOTS));
	end

endmodule

`default_nettype wire

### rtl/ab_feed_sequence_arbiter.sv
// Top level: A/B feed sequence arbiter with a reorder ring held in RAM.
// Flow: a request is registered in IDLE and classified in CLASS; an in-order request
// drives its first delivery from CLASS into the output register when it can emit.
// Held messages then drain from DRAIN, one payload RAM read per delivery; requests are
// taken only in IDLE, and output backpressure stalls both CLASS and the drain.
// Reset: next expected number 1, ring valid bits, held and drop counts cleared at once.
`default_nettype none

module ab_feed_sequence_arbiter import abfsa_pkg::*; #(
	parameter int WINDOW_SLOTS = 64,
	parameter int SEQ_BITS     = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [SEQ_W-1:0] cfg_wdata,
	abfsa_in_if.sink              in_ch,
	abfsa_out_if.source           out_ch
);

	localparam int IDX_W  = $clog2(WINDOW_SLOTS);
	localparam int HELD_W = $clog2(WINDOW_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASS,
		ST_DRAIN
	} state_t;

	state_t state_q;

	logic [SEQ_BITS-1:0]     ne_q;
	logic [SEQ_BITS-1:0]     seq_q;
	logic [HANDLE_W-1:0]     handle_q;
	logic [LEN_W-1:0]        len_q;
	logic [WINDOW_SLOTS-1:0] valid_q;
	logic [HELD_W-1:0]       held_q;
	logic [DROP_W-1:0]       drop_q;

	logic                    out_valid_q;
	logic [SEQ_W-1:0]        out_seq_q;
	logic [HANDLE_W-1:0]     out_handle_q;
	logic [LEN_W-1:0]        out_len_q;
	logic                    out_last_q;
	logic [HELD_COUNT_W-1:0] out_held_q;
	logic [DROP_W-1:0]       out_drop_q;

	logic [SEQ_BITS+SEQ_W-1:0] seq_ext;
	logic [SEQ_BITS+SEQ_W-1:0] cfg_ext;
	logic [SEQ_BITS+SEQ_W-1:0] ne_ext;
	logic [SEQ_BITS-1:0]       seq_in;
	logic [SEQ_BITS-1:0]       cfg_seq;
	logic [SEQ_BITS-1:0]       ne_inc;
	logic [IDX_W-1:0]          nxt_idx;
	logic [IDX_W-1:0]          seq_idx;
	logic [IDX_W-1:0]          cur_idx;
	logic [HELD_W-1:0]         held_dec;
	logic [HELD_W-1:0]         held_after;
	logic                      can_emit;
	logic                      run_last;
	logic                      emit;
	logic                      store;
	logic [PAYLOAD_W-1:0]      rd_data;
	logic [HANDLE_W-1:0]       emit_handle;
	logic [LEN_W-1:0]          emit_len;
	seq_class_t                cls;

	// numbers are taken modulo 2^SEQ_BITS in both directions
	assign seq_ext = {{SEQ_BITS{1'b0}}, in_ch.seq_num};
	assign cfg_ext = {{SEQ_BITS{1'b0}}, cfg_wdata};
	assign ne_ext  = {{SEQ_W{1'b0}}, ne_q};
	assign seq_in  = seq_ext[SEQ_BITS-1:0];
	assign cfg_seq = cfg_ext[SEQ_BITS-1:0];

	assign ne_inc   = ne_q + SEQ_BITS'(1);
	assign nxt_idx  = ne_inc[IDX_W-1:0];
	assign seq_idx  = seq_q[IDX_W-1:0];
	assign cur_idx  = ne_q[IDX_W-1:0];
	assign held_dec = held_q - HELD_W'(1);

	abfsa_classify #(
		.SEQ_BITS     (SEQ_BITS),
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_classify (
		.seq      (seq_q),
		.next_exp (ne_q),
		.cls      (cls)
	);

	always_comb begin
		can_emit   = !out_valid_q || out_ch.ready;
		held_after = (state_q == ST_DRAIN) ? held_dec : held_q;
		run_last   = (held_after == '0) || !valid_q[nxt_idx];
		emit       = 1'b0;
		store      = 1'b0;
		case (state_q)
			ST_CLASS: begin
				emit  = cls.is_next && can_emit;
				store = !cls.is_next && !cls.is_old && !cls.is_far && !valid_q[seq_idx];
			end
			ST_DRAIN: begin
				emit = can_emit;
			end
			default: begin
				emit  = 1'b0;
				store = 1'b0;
			end
		endcase
		if (state_q == ST_DRAIN) begin
			emit_handle = rd_data[PAYLOAD_W-1:LEN_W];
			emit_len    = rd_data[LEN_W-1:0];
		end else begin
			emit_handle = handle_q;
			emit_len    = len_q;
		end
	end

	// read of the following slot is issued with each delivery
	abfsa_ram #(
		.WIDTH (PAYLOAD_W),
		.DEPTH (WINDOW_SLOTS)
	) u_ring (
		.clk   (clk),
		.we    (store),
		.waddr (seq_idx),
		.wdata ({handle_q, len_q}),
		.re    (emit),
		.raddr (nxt_idx),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ne_q        <= SEQ_BITS'(1);
			valid_q     <= '0;
			held_q      <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q  <= 1'b1;
				out_seq_q    <= ne_ext[SEQ_W-1:0];
				out_handle_q <= emit_handle;
				out_len_q    <= emit_len;
				out_last_q   <= run_last;
				out_held_q   <= HELD_COUNT_W'(held_after);
				out_drop_q   <= drop_q;
				ne_q         <= ne_inc;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_we) begin
						ne_q    <= cfg_seq;
						valid_q <= '0;
						held_q  <= '0;
						drop_q  <= '0;
					end
					if (in_ch.valid) begin
						seq_q    <= seq_in;
						handle_q <= in_ch.payload_handle;
						len_q    <= in_ch.payload_len;
						state_q  <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					if (cls.is_next) begin
						if (can_emit) begin
							state_q <= run_last ? ST_IDLE : ST_DRAIN;
						end
					end else begin
						if (cls.is_far && drop_q != DROP_MAX) begin
							drop_q <= drop_q + DROP_W'(1);
						end
						if (store) begin
							valid_q[seq_idx] <= 1'b1;
							held_q           <= held_q + HELD_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_DRAIN: begin
					if (can_emit) begin
						valid_q[cur_idx] <= 1'b0;
						held_q           <= held_dec;
						state_q          <= run_last ? ST_IDLE : ST_DRAIN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_seq     = out_seq_q;
	assign out_ch.out_handle  = out_handle_q;
	assign out_ch.out_len     = out_len_q;
	assign out_ch.last_of_run = out_last_q;
	assign out_ch.held_count  = out_held_q;
	assign out_ch.drop_total  = out_drop_q;

	a_held_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(held_q))
		else $error("held count disagrees with ring valid bits");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(held_q) <= WINDOW_SLOTS)
		else $error("held count exceeds ring size");

	a_drain_slot_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> valid_q[cur_idx] && held_q != '0)
		else $error("drain of an empty slot");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_last_q |-> state_q == ST_DRAIN)
		else $error("unfinished run without drain");

	a_no_store_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		store |-> state_q == ST_CLASS && !emit)
		else $error("ring write overlaps a delivery");

endmodule

`default_nettype wire
